### hw/rtl/assert_macros.svh
// shared assertion shorthands, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold on every clock edge
`define GDAG_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// same-cycle implication
`define GDAG_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GDAG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gdag_pkg.sv
package gdag_pkg;

    localparam int NOMINAL_FREQ_MHZ     = 60000;
    localparam int DEFAULT_DEADBAND_MHZ = 25;

    // digit-serial multiplier geometry
    localparam int DIGIT_W   = 8;
    localparam int MCAND_W   = 32;
    localparam int MPLIER_W  = 64;
    localparam int SUM_W     = MCAND_W + DIGIT_W;
    localparam int PROD_W    = MCAND_W + MPLIER_W;
    localparam int CNT_W     = 4;

    // digit counts for the four passes
    localparam logic [CNT_W-1:0] NDIG_WORD  = CNT_W'(4);
    localparam logic [CNT_W-1:0] NDIG_AGC   = CNT_W'(6);
    localparam logic [CNT_W-1:0] NDIG_DWORD = CNT_W'(8);

    // configuration register indexes
    localparam logic [2:0] CFG_FREQ_DEADBAND  = 3'd0;
    localparam logic [2:0] CFG_DROOP_COEFF    = 3'd1;
    localparam logic [2:0] CFG_AGC_COEFF      = 3'd2;
    localparam logic [2:0] CFG_MIN_RAMP_STEP  = 3'd3;
    localparam logic [2:0] CFG_MAX_RAMP_STEP  = 3'd4;
    localparam logic [2:0] CFG_MIN_OUTPUT     = 3'd5;
    localparam logic [2:0] CFG_MAX_OUTPUT     = 3'd6;
    localparam logic [2:0] CFG_RATED_CAPACITY = 3'd7;

    // generator status codes
    localparam logic [2:0] STAT_OFF   = 3'd0;
    localparam logic [2:0] STAT_RISE  = 3'd1;
    localparam logic [2:0] STAT_FALL  = 3'd2;
    localparam logic [2:0] STAT_FLOOR = 3'd3;
    localparam logic [2:0] STAT_RUN   = 3'd4;
    localparam logic [2:0] STAT_CEIL  = 3'd5;
    localparam logic [2:0] STAT_OVER  = 3'd6;

    typedef struct packed {
        logic [16:0]        frequency_mhz;
        logic signed [31:0] area_control_error;
    } t_gdag_in;

    typedef struct packed {
        logic signed [31:0] power_output;
        logic [2:0]         gen_status;
    } t_gdag_out;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] ndig;
    } t_smul_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_smul_sts;

endpackage

### hw/rtl/gdag_smul.sv
`include "assert_macros.svh"

module gdag_smul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gdag_pkg::t_smul_ctl              i_ctl,
    input  logic [gdag_pkg::MCAND_W-1:0]     i_mcand,
    input  logic [gdag_pkg::MPLIER_W-1:0]    i_mplier,
    output gdag_pkg::t_smul_sts              o_sts,
    output logic [gdag_pkg::PROD_W-1:0]      o_prod
);

    logic [gdag_pkg::MCAND_W-1:0]  r_a;
    logic [gdag_pkg::MPLIER_W-1:0] r_b;
    logic [gdag_pkg::MCAND_W-1:0]  r_acc;
    logic [gdag_pkg::MPLIER_W-1:0] r_lo;
    logic [gdag_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [gdag_pkg::SUM_W-1:0]    w_pp;
    logic [gdag_pkg::SUM_W-1:0]    w_sum;

    // one multiplier digit per cycle while busy, low product bits shift out into r_lo
    assign w_pp  = gdag_pkg::SUM_W'(r_a) * gdag_pkg::SUM_W'(r_b[gdag_pkg::DIGIT_W-1:0]);
    assign w_sum = {{gdag_pkg::DIGIT_W{1'b0}}, r_acc} + w_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.ndig;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == gdag_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a   <= i_mcand;
            r_b   <= i_mplier;
            r_acc <= '0;
            r_lo  <= '0;
        end else if (r_busy) begin
            r_acc <= w_sum[gdag_pkg::SUM_W-1:gdag_pkg::DIGIT_W];
            r_lo  <= {w_sum[gdag_pkg::DIGIT_W-1:0], r_lo[gdag_pkg::MPLIER_W-1:gdag_pkg::DIGIT_W]};
            r_b   <= r_b >> gdag_pkg::DIGIT_W;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = {r_acc, r_lo};

    `GDAG_ASSERT_IMPL(a_start_when_free, i_ctl.start, !r_busy, "multiplier started while busy")
    `GDAG_ASSERT_IMPL(a_done_not_busy, r_done, !r_busy, "done raised while still stepping")
    `GDAG_ASSERT_IMPL(a_busy_count, r_busy, r_cnt != '0, "busy with empty digit count")

endmodule

### hw/rtl/generator_droop_agc_governor.sv
// Generator governor: each input transaction is one control tick carrying the measured
// frequency (mHz) and the area control error (Q16.16 MW). The block adds a droop term when
// the frequency error leaves the deadband and an AGC term proportional to output times ACE,
// applies the ramp step limits, clamps to the output limits (holds the output if they are
// inverted) and returns the new output with its status. All products run through one shared
// 32x8 digit-serial multiplier in four passes (4, 8, 4 and 6 digit steps), followed by four
// short register stages for the sum, ramp limit, output add and classification. The result
// register is loaded in the classification stage once the previous result is not held and
// the next item is taken in the cycle after that; none is taken while one is in progress.
// Configuration writes are always taken and must only be made while no tick is in progress.
`include "assert_macros.svh"

module generator_droop_agc_governor (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  gdag_pkg::t_gdag_in    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output gdag_pkg::t_gdag_out   o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_SUM   = 6'b000100,
        S_RAMP  = 6'b001000,
        S_ADD   = 6'b010000,
        S_CLASS = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        OP_DROOP_A = 2'd0,
        OP_DROOP_B = 2'd1,
        OP_AGC_A   = 2'd2,
        OP_AGC_B   = 2'd3
    } t_mul_op;

    function automatic logic signed [31:0] f_term(input logic ovf, input logic [30:0] mag,
                                                 input logic neg);
        logic signed [31:0] v;
        if (ovf) begin
            v = neg ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            v = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
        return v;
    endfunction

    function automatic logic signed [31:0] f_sat33(input logic [32:0] s);
        logic signed [31:0] v;
        if (s[32] != s[31]) begin
            v = s[32] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            v = $signed(s[31:0]);
        end
        return v;
    endfunction

    // configuration
    logic [9:0]         r_deadband;
    logic [31:0]        r_droop_coeff;
    logic [31:0]        r_agc_coeff;
    logic [30:0]        r_min_step;
    logic [30:0]        r_max_step;
    logic signed [31:0] r_min_out;
    logic signed [31:0] r_max_out;
    logic [30:0]        r_rated;

    // state and working registers
    t_state             r_state;
    t_mul_op            r_op;
    logic signed [31:0] r_pwr;
    logic [16:0]        r_df_mag;
    logic               r_df_neg;
    logic               r_outside;
    logic [31:0]        r_ace_mag;
    logic               r_ace_neg;
    logic signed [31:0] r_droop;
    logic signed [31:0] r_agc;
    logic signed [31:0] r_dp;
    logic signed [31:0] r_pn;
    logic               r_out_valid;
    gdag_pkg::t_gdag_out r_out_data;

    logic signed [31:0] n_dp;
    logic signed [31:0] n_act;
    logic [2:0]         n_status;

    logic               w_in_acc;
    logic               w_load;
    logic [17:0]        w_df;
    logic [17:0]        w_df_abs;
    logic [9:0]         w_db;
    logic [31:0]        w_pwr_abs;
    logic [31:0]        w_dp_abs;
    logic [31:0]        w_min_step;
    logic [31:0]        w_max_step;
    logic signed [31:0] w_rated;
    logic               w_floor_bad;

    gdag_pkg::t_smul_ctl                w_ctl;
    gdag_pkg::t_smul_sts                w_sts;
    logic [gdag_pkg::MCAND_W-1:0]       w_mcand;
    logic [gdag_pkg::MPLIER_W-1:0]      w_mplier;
    logic [gdag_pkg::PROD_W-1:0]        w_prod;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_df      = 18'(gdag_pkg::NOMINAL_FREQ_MHZ) - {1'b0, i_in_data.frequency_mhz};
    assign w_df_abs  = w_df[17] ? (18'd0 - w_df) : w_df;
    assign w_db      = (r_deadband == '0) ? 10'(gdag_pkg::DEFAULT_DEADBAND_MHZ) : r_deadband;
    assign w_pwr_abs = r_pwr[31] ? (32'd0 - r_pwr) : r_pwr;
    assign w_rated   = $signed({1'b0, r_rated});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband    <= 10'(gdag_pkg::DEFAULT_DEADBAND_MHZ);
            r_droop_coeff <= '0;
            r_agc_coeff   <= '0;
            r_min_step    <= '0;
            r_max_step    <= '0;
            r_min_out     <= '0;
            r_max_out     <= '0;
            r_rated       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                gdag_pkg::CFG_FREQ_DEADBAND:  r_deadband    <= i_cfg_data[9:0];
                gdag_pkg::CFG_DROOP_COEFF:    r_droop_coeff <= i_cfg_data;
                gdag_pkg::CFG_AGC_COEFF:      r_agc_coeff   <= i_cfg_data;
                gdag_pkg::CFG_MIN_RAMP_STEP:  r_min_step    <= i_cfg_data[30:0];
                gdag_pkg::CFG_MAX_RAMP_STEP:  r_max_step    <= i_cfg_data[30:0];
                gdag_pkg::CFG_MIN_OUTPUT:     r_min_out     <= $signed(i_cfg_data);
                gdag_pkg::CFG_MAX_OUTPUT:     r_max_out     <= $signed(i_cfg_data);
                gdag_pkg::CFG_RATED_CAPACITY: r_rated       <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // multiplier passes: the first starts on accept, each later one on the prior done
    always_comb begin
        w_ctl.start = 1'b0;
        w_ctl.ndig  = gdag_pkg::NDIG_WORD;
        w_mcand     = r_droop_coeff;
        w_mplier    = {32'd0, w_pwr_abs};
        if (w_in_acc) begin
            w_ctl.start = 1'b1;
        end else if (r_state == S_MUL && w_sts.done) begin
            case (r_op)
                OP_DROOP_A: begin
                    // |P| * droop_coeff times |df|
                    w_ctl.start = 1'b1;
                    w_ctl.ndig  = gdag_pkg::NDIG_DWORD;
                    w_mcand     = {15'd0, r_df_mag};
                    w_mplier    = w_prod[95:32];
                end
                OP_DROOP_B: begin
                    w_ctl.start = 1'b1;
                    w_mcand     = r_ace_mag;
                end
                OP_AGC_A: begin
                    // floor(|P| * |ACE| / 2^16) times agc_coeff
                    w_ctl.start = 1'b1;
                    w_ctl.ndig  = gdag_pkg::NDIG_AGC;
                    w_mcand     = r_agc_coeff;
                    w_mplier    = {16'd0, w_prod[95:48]};
                end
                default: ;
            endcase
        end
    end

    gdag_smul u_smul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_sts    (w_sts),
        .o_prod   (w_prod)
    );

    // ramp step limits
    assign w_dp_abs   = r_dp[31] ? (32'd0 - r_dp) : r_dp;
    assign w_min_step = {1'b0, r_min_step};
    assign w_max_step = {1'b0, r_max_step};

    always_comb begin
        n_dp = r_dp;
        if (w_min_step < w_max_step) begin
            if (r_dp != '0 && w_dp_abs < w_min_step) begin
                n_dp = r_dp[31] ? $signed(32'd0 - w_min_step) : $signed(w_min_step);
            end else if (w_dp_abs > w_max_step) begin
                n_dp = r_dp[31] ? $signed(32'd0 - w_max_step) : $signed(w_max_step);
            end
        end
    end

    // output clamp and status
    always_comb begin
        n_act    = r_pn;
        n_status = gdag_pkg::STAT_RUN;
        if (r_max_out < r_min_out) begin
            n_act    = r_pwr;
            n_status = gdag_pkg::STAT_OFF;
        end else begin
            if (r_min_out > 32'sd0 && r_pn < r_min_out) begin
                n_act    = r_min_out;
                n_status = gdag_pkg::STAT_FLOOR;
            end else if (r_max_out > r_min_out && r_pn > r_max_out) begin
                n_act    = r_max_out;
                n_status = gdag_pkg::STAT_CEIL;
            end else if (r_pn < r_min_out) begin
                if (r_pn > 32'sd0 && r_dp > 32'sd0) begin
                    n_status = gdag_pkg::STAT_RISE;
                end else if (r_pn > 32'sd0 && r_dp < 32'sd0) begin
                    n_status = gdag_pkg::STAT_FALL;
                end else begin
                    n_status = gdag_pkg::STAT_OFF;
                end
            end
            if (n_act > w_rated) begin
                n_status = gdag_pkg::STAT_OVER;
            end
        end
    end

    assign w_load = (r_state == S_CLASS) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_DROOP_A;
            r_pwr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_MUL;
                        r_op    <= OP_DROOP_A;
                    end
                end
                S_MUL: begin
                    if (w_sts.done) begin
                        case (r_op)
                            OP_DROOP_A: r_op <= OP_DROOP_B;
                            OP_DROOP_B: r_op <= OP_AGC_A;
                            OP_AGC_A:   r_op <= OP_AGC_B;
                            default:    r_state <= S_SUM;
                        endcase
                    end
                end
                S_SUM:   r_state <= S_RAMP;
                S_RAMP:  r_state <= S_ADD;
                S_ADD:   r_state <= S_CLASS;
                S_CLASS: begin
                    if (w_load) begin
                        r_pwr   <= n_act;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_df_mag  <= w_df_abs[16:0];
            r_df_neg  <= w_df[17];
            r_outside <= (w_df_abs[16:0] > {7'd0, w_db});
            r_ace_mag <= i_in_data.area_control_error[31]
                         ? (32'd0 - i_in_data.area_control_error)
                         : i_in_data.area_control_error;
            r_ace_neg <= i_in_data.area_control_error[31];
        end
        if (r_state == S_MUL && w_sts.done && r_op == OP_DROOP_B) begin
            // product bits 30 and up form the term, anything from bit 61 saturates
            r_droop <= r_outside ? f_term(|w_prod[95:61], w_prod[60:30], r_df_neg ^ r_pwr[31])
                                 : 32'sd0;
        end
        if (r_state == S_MUL && w_sts.done && r_op == OP_AGC_B) begin
            r_agc <= f_term(|w_prod[95:77], w_prod[76:46], r_ace_neg ^ r_pwr[31]);
        end
        if (r_state == S_SUM) begin
            r_dp <= f_sat33({r_droop[31], r_droop} + {r_agc[31], r_agc});
        end
        if (r_state == S_RAMP) begin
            r_dp <= n_dp;
        end
        if (r_state == S_ADD) begin
            r_pn <= f_sat33({r_pwr[31], r_pwr} + {r_dp[31], r_dp});
        end
        if (w_load) begin
            r_out_data.power_output <= n_act;
            r_out_data.gen_status   <= n_status;
        end
    end

    assign w_floor_bad = r_out_valid && (r_out_data.gen_status == gdag_pkg::STAT_FLOOR)
                         && (r_out_data.power_output <= 32'sd0);

    `GDAG_ASSERT_IMPL(a_done_in_mul, w_sts.done, r_state == S_MUL, "done outside pass sequence")
    `GDAG_ASSERT_NEXT(a_accept_to_mul, w_in_acc, r_state == S_MUL && w_sts.busy, "not started")
    `GDAG_ASSERT_IMPL(a_mul_quiet, r_state != S_MUL, !w_sts.busy, "busy outside passes")
    `GDAG_ASSERT(a_min_positive, !w_floor_bad, "minimum status with non-positive output")

endmodule

### dv/tb_generator_droop_agc_governor.sv
module tb_generator_droop_agc_governor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MW = 65536;

    typedef struct {
        logic [9:0]         deadband;
        logic [31:0]        droop;
        logic [31:0]        agc;
        logic [30:0]        min_step;
        logic [30:0]        max_step;
        logic signed [31:0] min_out;
        logic signed [31:0] max_out;
        logic [30:0]        rated;
    } t_gov_regs;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    gdag_pkg::t_gdag_in  in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    gdag_pkg::t_gdag_out out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index = '0;
    logic [31:0]         cfg_data  = '0;

    // governor model state and its copy of the registers
    t_gov_regs          regs_now;
    logic signed [31:0] gen_power = '0;
    logic [2:0]         gen_state = gdag_pkg::STAT_OFF;

    gdag_pkg::t_gdag_out pending_outputs[$];
    gdag_pkg::t_gdag_out want_out;
    int        mismatches = 0;
    int        idle_pct   = 0;
    int        stall_pct  = 0;

    generator_droop_agc_governor u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic t_gov_regs make_regs(input logic [31:0] deadband, input logic [31:0] droop,
                                            input logic [31:0] agc, input logic [31:0] min_step,
                                            input logic [31:0] max_step,
                                            input logic signed [31:0] min_out,
                                            input logic signed [31:0] max_out,
                                            input logic [31:0] rated);
        t_gov_regs r;
        r.deadband = deadband[9:0];
        r.droop    = droop;
        r.agc      = agc;
        r.min_step = min_step[30:0];
        r.max_step = max_step[30:0];
        r.min_out  = min_out;
        r.max_out  = max_out;
        r.rated    = rated[30:0];
        return r;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // magnitude capped at 2^31 before the sign goes on, then clipped
    function automatic logic signed [63:0] signed_term(input logic [127:0] mag, input logic neg);
        logic signed [63:0] v;
        if (mag > 128'h8000_0000) v = 64'sh8000_0000;
        else v = $signed(mag[63:0]);
        if (neg) v = -v;
        return clip32(v);
    endfunction

    function automatic gdag_pkg::t_gdag_out govern_tick(input gdag_pkg::t_gdag_in tick);
        logic signed [63:0]  act, ace, df, dp, p, mo, mx, step_lo, step_hi;
        logic [63:0]         aact, adf, db, a;
        logic [127:0]        m;
        gdag_pkg::t_gdag_out res;
        act = gen_power;
        ace = $signed(tick.area_control_error);
        mo  = regs_now.min_out;
        mx  = regs_now.max_out;
        if (mx >= mo) begin
            df   = 64'(gdag_pkg::NOMINAL_FREQ_MHZ) - $signed({47'b0, tick.frequency_mhz});
            db   = (regs_now.deadband != 0) ? 64'(regs_now.deadband)
                                            : 64'(gdag_pkg::DEFAULT_DEADBAND_MHZ);
            aact = magnitude(act);
            adf  = magnitude(df);
            dp   = 0;
            if (adf > db) begin
                m  = (128'(adf) * 128'(aact) * 128'(regs_now.droop)) >> 30;
                dp = dp + signed_term(m, (df < 0) != (act < 0));
            end
            m  = (128'((aact * magnitude(ace)) >> 16) * 128'(regs_now.agc)) >> 30;
            dp = clip32(dp + signed_term(m, (ace < 0) != (act < 0)));

            step_lo = $signed(64'(regs_now.min_step));
            step_hi = $signed(64'(regs_now.max_step));
            if (regs_now.min_step < regs_now.max_step) begin
                a = magnitude(dp);
                if (dp != 0 && a < 64'(regs_now.min_step))
                    dp = (dp < 0) ? -step_lo : step_lo;
                else if (a > 64'(regs_now.max_step))
                    dp = (dp < 0) ? -step_hi : step_hi;
            end

            p = clip32(act + dp);
            if (mo > 0 && p < mo) begin
                act       = mo;
                gen_state = gdag_pkg::STAT_FLOOR;
            end else if (mx > mo && p > mx) begin
                act       = mx;
                gen_state = gdag_pkg::STAT_CEIL;
            end else if (p < mo) begin
                act = p;
                if (p > 0 && dp > 0) gen_state = gdag_pkg::STAT_RISE;
                else if (p > 0 && dp < 0) gen_state = gdag_pkg::STAT_FALL;
                else gen_state = gdag_pkg::STAT_OFF;
            end else begin
                act       = p;
                gen_state = gdag_pkg::STAT_RUN;
            end
            if (act > $signed(64'(regs_now.rated))) gen_state = gdag_pkg::STAT_OVER;
            gen_power = act[31:0];
        end else begin
            // inverted limits: output holds
            gen_state = gdag_pkg::STAT_OFF;
        end
        res.power_output = gen_power;
        res.gen_status   = gen_state;
        return res;
    endfunction

    task automatic set_idling(input int send_pct, input int rcv_pct);
        idle_pct  = send_pct;
        stall_pct = rcv_pct;
    endtask

    // valid stays high after acceptance so back-to-back ticks need no extra edge
    task automatic send_tick(input logic [16:0] freq, input logic [31:0] ace);
        gdag_pkg::t_gdag_in item;
        item.frequency_mhz      = freq;
        item.area_control_error = ace;
        if ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_outputs.push_back(govern_tick(item));
    endtask

    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_outputs.size() != 0) @(posedge clk);
    endtask

    task automatic load_regs(input t_gov_regs r);
        logic [31:0] word [8];
        word[gdag_pkg::CFG_FREQ_DEADBAND]  = {22'b0, r.deadband};
        word[gdag_pkg::CFG_DROOP_COEFF]    = r.droop;
        word[gdag_pkg::CFG_AGC_COEFF]      = r.agc;
        word[gdag_pkg::CFG_MIN_RAMP_STEP]  = {1'b0, r.min_step};
        word[gdag_pkg::CFG_MAX_RAMP_STEP]  = {1'b0, r.max_step};
        word[gdag_pkg::CFG_MIN_OUTPUT]     = r.min_out;
        word[gdag_pkg::CFG_MAX_OUTPUT]     = r.max_out;
        word[gdag_pkg::CFG_RATED_CAPACITY] = {1'b0, r.rated};
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= word[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        regs_now = r;
    endtask

    function automatic t_gov_regs rand_regs();
        t_gov_regs r;
        longint    v;
        case ($urandom_range(0, 3))
            0: r.deadband = '0;
            1: r.deadband = 10'd1000;
            2: r.deadband = 10'd25;
            default: r.deadband = 10'($urandom_range(0, 1000));
        endcase
        case ($urandom_range(0, 4))
            0: r.droop = '0;
            1: r.droop = 32'hffff_ffff;
            2, 3: r.droop = $urandom_range(0, 1 << 22);
            default: r.droop = $urandom();
        endcase
        case ($urandom_range(0, 4))
            0: r.agc = '0;
            1: r.agc = 32'hffff_ffff;
            2, 3: r.agc = $urandom_range(0, 1 << 28);
            default: r.agc = $urandom();
        endcase
        case ($urandom_range(0, 3))
            0: r.min_step = '0;
            1: r.min_step = 31'h7fff_ffff;
            default: r.min_step = 31'($urandom_range(0, 1 << 18));
        endcase
        case ($urandom_range(0, 4))
            0: r.max_step = '0;
            1: r.max_step = 31'h7fff_ffff;
            2: r.max_step = r.min_step;
            default: r.max_step = 31'($urandom_range(0, 1 << 22));
        endcase
        case ($urandom_range(0, 5))
            0: r.min_out = 32'sh8000_0000;
            1: r.min_out = '0;
            2, 3: r.min_out = $urandom_range(1, 200 * MW);
            4: begin
                v         = -longint'($urandom_range(0, 200 * MW));
                r.min_out = v[31:0];
            end
            default: r.min_out = $urandom();
        endcase
        case ($urandom_range(0, 6))
            0: v = 64'sd2147483647;
            1: v = r.min_out;
            2: v = longint'(r.min_out) - longint'($urandom_range(1, 50 * MW));
            default: v = longint'(r.min_out) + longint'($urandom_range(1, 400 * MW));
        endcase
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        r.max_out = v[31:0];
        case ($urandom_range(0, 3))
            0: r.rated = '0;
            1: r.rated = 31'h7fff_ffff;
            2: r.rated = 31'($urandom_range(0, 500 * MW));
            default: r.rated = 31'($urandom());
        endcase
        return r;
    endfunction

    task automatic random_tick();
        longint f;
        longint a;
        int     pick;
        if ($urandom_range(0, 9) < 8)
            f = longint'(gdag_pkg::NOMINAL_FREQ_MHZ) - 3000 + longint'($urandom_range(0, 6000));
        else
            f = $urandom_range(0, 131071);
        pick = $urandom_range(0, 19);
        if (pick < 12) a = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
        else if (pick < 17) a = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
        else a = $urandom();
        send_tick(f[16:0], a[31:0]);
    endtask

    task automatic test_reset_state();
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ), 32'sd0);
        send_tick(17'd0, 32'sh8000_0000);
        send_tick(17'h1ffff, 32'sh7fff_ffff);
    endtask

    task automatic test_inverted_limits();
        settle_block();
        load_regs(make_regs(25, 0, 0, 0, 0, 10 * MW, 5 * MW, 0));
        send_tick(17'd59000, MW);
    endtask

    task automatic test_minimum_clamp();
        settle_block();
        load_regs(make_regs(25, 0, 0, 0, 0, 100 * MW, 400 * MW, 350 * MW));
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ), 32'sd0);
    endtask

    task automatic test_droop_deadband();
        settle_block();
        // zero deadband behaves as the default one
        load_regs(make_regs(0, 1 << 20, 0, 0, 0, 0, 400 * MW, 350 * MW));
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ - 25), 32'sd0);
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ + 25), 32'sd0);
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ - 26), 32'sd0);
        send_tick(17'd59000, 32'sd0);
        settle_block();
        load_regs(make_regs(1000, 1 << 20, 0, 0, 0, 0, 400 * MW, 350 * MW));
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ - 1000), 32'sd0);
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ - 1001), 32'sd0);
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ + 1001), 32'sd0);
    endtask

    task automatic test_agc_and_caps();
        settle_block();
        load_regs(make_regs(25, 0, 1 << 30, 0, 0, 0, 400 * MW, 350 * MW));
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ), 32'sd16384);
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ), -32'sd16384);
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ), 32'sd0);
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ), 32'sh7fff_ffff);
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ), 32'sh8000_0000);
    endtask

    task automatic test_ramp_limits();
        settle_block();
        load_regs(make_regs(25, 0, 1 << 24, MW, 8 * MW, 100 * MW, 400 * MW, 500 * MW));
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ), 32'sd0);
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ), 32'sd1024);
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ), 32'sd4194304);
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ), -32'sd4194304);
        settle_block();
        // equal steps switch the ramp limit off
        load_regs(make_regs(25, 0, 1 << 24, 8 * MW, 8 * MW, 100 * MW, 400 * MW, 500 * MW));
        send_tick(17'(gdag_pkg::NOMINAL_FREQ_MHZ), 32'sd4194304);
    endtask

    task automatic test_saturation();
        settle_block();
        load_regs(make_regs(1000, 32'hffff_ffff, 32'hffff_ffff, 0, 32'h7fff_ffff,
                            32'sh8000_0000, 32'sh7fff_ffff, 32'h7fff_ffff));
        send_tick(17'd0, 32'sh7fff_ffff);
        send_tick(17'h1ffff, 32'sh8000_0000);
        send_tick(17'd0, 32'sh8000_0000);
        settle_block();
        load_regs(make_regs(1000, 32'hffff_ffff, 32'hffff_ffff, 0, 32'h7fff_ffff,
                            32'sh8000_0000, 32'sh8000_0000, 0));
        send_tick(17'h1ffff, 32'sh7fff_ffff);
    endtask

    task automatic test_random_mix();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: set_idling(0, 0);
                1: set_idling(46, 0);
                2: set_idling(0, 46);
                default: set_idling(23, 23);
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                settle_block();
                if (ph == 0 && seg == 0)
                    load_regs(make_regs(1000, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_fffe,
                                        32'h7fff_ffff, 1, 32'sh7fff_ffff, 32'h7fff_ffff));
                else if (ph == 1 && seg == 0)
                    load_regs(make_regs(0, 1, 1, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 0));
                else
                    load_regs(rand_regs());
                repeat (61) random_tick();
            end
        end
    endtask

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: result with nothing pending: power %0d status %0d", $time,
                         $signed(out_data.power_output), out_data.gen_status);
                mismatches++;
            end else begin
                want_out = pending_outputs.pop_front();
                if (out_data.power_output !== want_out.power_output) begin
                    $display("%0t: power_output expected %0d actual %0d", $time,
                             $signed(want_out.power_output), $signed(out_data.power_output));
                    mismatches++;
                end
                if (out_data.gen_status !== want_out.gen_status) begin
                    $display("%0t: gen_status expected %0d actual %0d", $time,
                             want_out.gen_status, out_data.gen_status);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        regs_now = make_regs(gdag_pkg::DEFAULT_DEADBAND_MHZ, 0, 0, 0, 0, 0, 0, 0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_reset_state();
        test_inverted_limits();
        test_minimum_clamp();
        test_droop_deadband();
        test_agc_and_caps();
        test_ramp_limits();
        test_saturation();
        test_random_mix();

        settle_block();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_outputs.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### generator_droop_agc_governor.f
+incdir+hw/rtl
hw/rtl/gdag_pkg.sv
hw/rtl/gdag_smul.sv
hw/rtl/generator_droop_agc_governor.sv
dv/tb_generator_droop_agc_governor.sv
